// File: hdl/lbrd_pkg.sv
// ----------------------------------------------------------------------------
// lbrd_pkg
// shared widths, constants, control structs and the lfsr feedback function
// ----------------------------------------------------------------------------
package lbrd_pkg;

  localparam int DRAW_BITS = 9;
  localparam int BOUND_W   = 15;
  localparam int SEED_W    = 32;
  localparam int VALUE_W   = 10;
  localparam int TMP_W     = (DRAW_BITS + 1 > BOUND_W + 1) ? DRAW_BITS + 1 : BOUND_W + 1;
  localparam int CNT_W     = $clog2(DRAW_BITS + 1);

  localparam logic [SEED_W-1:0] SEED_RESET  = 32'h3568_3568;
  localparam logic [SEED_W-1:0] SEED_ESCAPE = 32'd12478;

  localparam logic ACT_DRAW = 1'b0;
  localparam logic ACT_LOAD = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic last;
  } lbrd_lfsr_ctl_t;

  typedef struct packed {
    logic clear;
    logic step;
  } lbrd_rem_ctl_t;

  // taps 0, 1, 2, 4, 6 and 31
  function automatic logic lbrd_feedback(input logic [SEED_W-1:0] s);
    lbrd_feedback = s[0] ^ s[1] ^ s[2] ^ s[4] ^ s[6] ^ s[31];
  endfunction

endpackage

// File: hdl/lbrd_stream_if.sv
// ----------------------------------------------------------------------------
// lbrd request and response channels
// valid/ready channels carrying the draw request and its response
// ----------------------------------------------------------------------------
interface lbrd_req_if;
  logic                         valid;
  logic                         ready;
  logic                         action;
  logic [lbrd_pkg::BOUND_W-1:0] bound;
  logic [lbrd_pkg::SEED_W-1:0]  seed_value;

  modport source (output valid, output action, output bound, output seed_value,
                  input ready);
  modport sink   (input valid, input action, input bound, input seed_value,
                  output ready);
endinterface

interface lbrd_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [lbrd_pkg::VALUE_W-1:0] value;
  logic                         error;
  logic [lbrd_pkg::SEED_W-1:0]  seed_now;

  modport source (output valid, output value, output error, output seed_now,
                  input ready);
  modport sink   (input valid, input value, input error, input seed_now,
                  output ready);
endinterface

// File: hdl/lbrd_lfsr.sv
// ----------------------------------------------------------------------------
// lbrd_lfsr
// seed register with one fibonacci lfsr step per cycle while step is set
// ----------------------------------------------------------------------------
module lbrd_lfsr (
  input  logic                         clk,
  input  logic                         rst,
  input  lbrd_pkg::lbrd_lfsr_ctl_t     ctl,
  input  logic [lbrd_pkg::SEED_W-1:0]  load_value,
  output logic [lbrd_pkg::SEED_W-1:0]  seed,
  output logic [lbrd_pkg::SEED_W-1:0]  seed_next,
  output logic                         fb
);
  import lbrd_pkg::*;

  logic [SEED_W-1:0] stepped;

  always_comb begin
    fb        = lbrd_feedback(seed);
    stepped   = {fb, seed[SEED_W-1:1]};
    seed_next = seed;
    if (ctl.load) begin
      seed_next = load_value;
    end else if (ctl.step) begin
      seed_next = stepped;
      // an all-zero seed would lock up, escape on the final step
      if (ctl.last && (stepped == '0)) begin
        seed_next = SEED_ESCAPE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= SEED_RESET;
    end else begin
      seed <= seed_next;
    end
  end

endmodule

// File: hdl/lbrd_rem.sv
// ----------------------------------------------------------------------------
// lbrd_rem
// restoring remainder, one dividend bit per cycle while step is set, msb first
// ----------------------------------------------------------------------------
module lbrd_rem (
  input  logic                          clk,
  input  lbrd_pkg::lbrd_rem_ctl_t       ctl,
  input  logic                          bit_in,
  input  logic [lbrd_pkg::BOUND_W-1:0]  bound,
  output logic [lbrd_pkg::DRAW_BITS-1:0] rem,
  output logic [lbrd_pkg::DRAW_BITS-1:0] rem_next
);
  import lbrd_pkg::*;

  logic [TMP_W-1:0] trial;

  always_comb begin
    trial = (TMP_W'(rem) << 1) | TMP_W'(bit_in);
    if (trial >= TMP_W'(bound)) begin
      trial = trial - TMP_W'(bound);
    end
    rem_next = rem;
    if (ctl.clear) begin
      rem_next = '0;
    end else if (ctl.step) begin
      rem_next = trial[DRAW_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    rem <= rem_next;
  end

endmodule

// File: hdl/lfsr_bounded_random_draw_unit.sv
// ----------------------------------------------------------------------------
// lfsr_bounded_random_draw_unit
// bounded random draw from a 32-bit fibonacci lfsr
// ----------------------------------------------------------------------------
// A draw request with bound n runs nine lfsr steps, one per clock, and feeds
// each new feedback bit straight into a restoring remainder stage, so the
// result (random mod n) + 1 is ready when the last step is done, and the
// response is registered as that last step is taken. Each step is the single
// lfsr step and the single compare/subtract of the remainder stage.
// A load request or a draw with bound zero is answered in the cycle after its
// transfer. The request side is not ready while a draw runs, or while an
// earlier response is still waiting and not being taken in the same cycle.
// Every response carries the seed as it stands after its request.
// ----------------------------------------------------------------------------
module lfsr_bounded_random_draw_unit (
  input logic        clk,
  input logic        rst,
  lbrd_req_if.sink   req,
  lbrd_rsp_if.source rsp
);
  import lbrd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t               state, state_next;
  logic [CNT_W-1:0]     cnt;
  logic [BOUND_W-1:0]   bound_q;
  logic                 req_xfer;
  logic                 last_step;
  logic                 is_load;
  logic                 is_error;

  lbrd_lfsr_ctl_t       lfsr_ctl;
  lbrd_rem_ctl_t        rem_ctl;
  logic [SEED_W-1:0]    seed;
  logic [SEED_W-1:0]    seed_next;
  logic                 fb;
  logic [DRAW_BITS-1:0] rem;
  logic [DRAW_BITS-1:0] rem_next;
  logic [TMP_W-1:0]     value_sum;

  // response register, free or being emptied before a new request is taken
  assign req.ready = (state == ST_IDLE) && (!rsp.valid || rsp.ready);
  assign req_xfer  = req.valid && req.ready;
  assign is_load   = req_xfer && (req.action == ACT_LOAD);
  assign is_error  = req_xfer && (req.action == ACT_DRAW) && (req.bound == '0);
  assign last_step = (state == ST_RUN) && (cnt == CNT_W'(DRAW_BITS - 1));

  // sequencer
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_xfer && (req.action == ACT_DRAW) && (req.bound != '0)) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_step) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      if (state == ST_RUN) begin
        cnt <= last_step ? '0 : cnt + CNT_W'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  // bound is held for the whole draw
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      bound_q <= req.bound;
    end
  end

  always_comb begin
    lfsr_ctl.load = is_load;
    lfsr_ctl.step = (state == ST_RUN);
    lfsr_ctl.last = last_step;
    rem_ctl.clear = req_xfer;
    rem_ctl.step  = (state == ST_RUN);
  end

  lbrd_lfsr u_lfsr (
    .clk        (clk),
    .rst        (rst),
    .ctl        (lfsr_ctl),
    .load_value (req.seed_value),
    .seed       (seed),
    .seed_next  (seed_next),
    .fb         (fb)
  );

  lbrd_rem u_rem (
    .clk      (clk),
    .ctl      (rem_ctl),
    .bit_in   (fb),
    .bound    (bound_q),
    .rem      (rem),
    .rem_next (rem_next)
  );

  assign value_sum = TMP_W'(rem_next) + TMP_W'(1);

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (is_load || is_error || last_step) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (is_load || is_error) begin
      rsp.value    <= '0;
      rsp.error    <= is_error;
      rsp.seed_now <= seed_next;
    end else if (last_step) begin
      rsp.value    <= value_sum[VALUE_W-1:0];
      rsp.error    <= 1'b0;
      rsp.seed_now <= seed_next;
    end
  end

  // checks
  a_ready_only_idle: assert property (@(posedge clk) disable iff (rst)
    req.ready |-> (state == ST_IDLE))
    else $error("request ready outside idle");

  a_no_rsp_while_run: assert property (@(posedge clk) disable iff (rst)
    (state == ST_RUN) |-> !rsp.valid)
    else $error("response pending during a draw");

  a_zero_bound_error: assert property (@(posedge clk) disable iff (rst)
    is_error |=> (rsp.valid && rsp.error && (rsp.value == '0) && $stable(seed)))
    else $error("zero bound not flagged or seed changed");

  a_rem_below_bound: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_RUN) && (cnt != '0)) |-> (TMP_W'(rem) < TMP_W'(bound_q)))
    else $error("remainder not below bound");

  a_draw_nonzero: assert property (@(posedge clk) disable iff (rst)
    last_step |=> (rsp.valid && !rsp.error && (rsp.seed_now != '0)))
    else $error("draw response malformed");

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for lfsr_bounded_random_draw_unit: a queue-fed request
// driver and a response monitor, with an in-bench lfsr model predicting every
// response, random idle bursts on both channels and one long response hold-off
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import lbrd_pkg::*;

  localparam int DIRECTED_MAX = 25;
  localparam int RANDOM_ITEMS = 626;
  localparam int QUIET_TAIL   = 80;   // last transfers run with no idling
  localparam int HOLD_AFTER   = 150;  // responses seen before the long hold-off
  localparam int HOLD_CYCLES  = 60;
  localparam int DRAIN_CYCLES = 20;

  typedef struct packed {
    logic               action;
    logic [BOUND_W-1:0] bound;
    logic [SEED_W-1:0]  seed_value;
  } draw_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               error;
    logic [SEED_W-1:0]  seed_now;
  } draw_result_t;

  logic clk;
  logic rst;

  lbrd_req_if req_ch ();
  lbrd_rsp_if rsp_ch ();

  lfsr_bounded_random_draw_unit u_top (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // requests waiting to be offered, and responses the model says are owed
  draw_req_t    pending_requests[$];
  draw_result_t expected_results[$];

  // seed as the model sees it after every accepted request
  logic [SEED_W-1:0] seed_shadow = SEED_RESET;

  int   total_items   = 0;
  int   items_sent    = 0;
  int   results_seen  = 0;
  int   fail_count    = 0;
  int   n_draws       = 0;
  int   n_loads       = 0;
  int   n_zero_bound  = 0;
  int   n_escapes     = 0;
  int   send_gap      = 0;
  int   stall_left    = 0;
  logic hold_off      = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // model of one request: a load swaps the seed, a zero bound flags an error,
  // a draw clocks the lfsr DRAW_BITS times and reduces the feedback bits
  function automatic draw_result_t predict_response(input logic [SEED_W-1:0] seed_in,
                                                    input draw_req_t r);
    logic [SEED_W-1:0] s;
    logic [15:0]       acc;
    logic              fb;
    draw_result_t      res;
    res.value = '0;
    res.error = 1'b0;
    s         = seed_in;
    acc       = '0;
    if (r.action == ACT_LOAD) begin
      s = r.seed_value;
    end else if (r.bound == '0) begin
      res.error = 1'b1;
    end else begin
      for (int k = 0; k < DRAW_BITS; k++) begin
        fb  = s[0] ^ s[1] ^ s[2] ^ s[4] ^ s[6] ^ s[31];
        acc = {acc[14:0], fb};
        s   = {fb, s[SEED_W-1:1]};
      end
      // an all-zero register would stay stuck, so it is kicked out
      if (s == '0) s = SEED_ESCAPE;
      res.value = VALUE_W'((32'(acc) % 32'(r.bound)) + 32'd1);
    end
    res.seed_now = s;
    return res;
  endfunction

  task automatic add_request(input logic act, input logic [BOUND_W-1:0] bnd,
                             input logic [SEED_W-1:0] sv);
    draw_req_t r;
    r.action     = act;
    r.bound      = bnd;
    r.seed_value = sv;
    pending_requests.push_back(r);
  endtask

  task automatic report_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // request driver: offers the head of the queue, predicts on each transfer
  always @(posedge clk) begin : req_driver
    logic         offer;
    draw_req_t    cur;
    draw_result_t res;
    if (rst) begin
      req_ch.valid      <= 1'b0;
      req_ch.action     <= ACT_DRAW;
      req_ch.bound      <= '0;
      req_ch.seed_value <= '0;
      send_gap = 0;
    end else begin
      offer = req_ch.valid;
      if (req_ch.valid && req_ch.ready) begin
        cur = pending_requests.pop_front();
        if (cur.action == ACT_LOAD) begin
          n_loads++;
        end else if (cur.bound == '0) begin
          n_zero_bound++;
        end else begin
          n_draws++;
          if (seed_shadow == '0) n_escapes++;
        end
        res         = predict_response(seed_shadow, cur);
        seed_shadow = res.seed_now;
        expected_results.push_back(res);
        items_sent++;
        offer = 1'b0;
        // idle bursts, except in every third window of 64 and in the tail
        if (items_sent < total_items - QUIET_TAIL && (items_sent / 64) % 3 != 2 &&
            $urandom_range(3) == 0)
          send_gap = $urandom_range(3, 1);
      end
      if (!offer) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_requests.size() > 0) begin
          offer = 1'b1;
          req_ch.action     <= pending_requests[0].action;
          req_ch.bound      <= pending_requests[0].bound;
          req_ch.seed_value <= pending_requests[0].seed_value;
        end
      end
      req_ch.valid <= offer;
    end
  end

  // response monitor: checks each transfer against the oldest prediction
  always @(posedge clk) begin : rsp_monitor
    logic         rdy;
    draw_result_t want;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_failure($sformatf("unexpected response value=%0d error=%0b seed=%08h",
                                   rsp_ch.value, rsp_ch.error, rsp_ch.seed_now));
        end else begin
          want = expected_results.pop_front();
          if (rsp_ch.value !== want.value)
            report_failure($sformatf("response %0d value exp %0d got %0d",
                                     results_seen, want.value, rsp_ch.value));
          if (rsp_ch.error !== want.error)
            report_failure($sformatf("response %0d error exp %0b got %0b",
                                     results_seen, want.error, rsp_ch.error));
          if (rsp_ch.seed_now !== want.seed_now)
            report_failure($sformatf("response %0d seed exp %08h got %08h",
                                     results_seen, want.seed_now, rsp_ch.seed_now));
        end
      end
      if (hold_off) begin
        rdy = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        rdy = 1'b0;
      end else if (results_seen < total_items - QUIET_TAIL &&
                   (results_seen / 64) % 3 != 1 && $urandom_range(4) == 0) begin
        // start a burst of stalled cycles, the rest counted down in stall_left
        rdy        = 1'b0;
        stall_left = $urandom_range(2, 0);
      end else begin
        rdy = 1'b1;
      end
      rsp_ch.ready <= rdy;
    end
  end

  // long hold-off on the response side: the sender keeps offering, so the
  // block's output register fills and it has to stall its request side
  initial begin
    wait (results_seen >= HOLD_AFTER);
    @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d requests sent, %0d responses seen", items_sent,
             results_seen);
    $display("TB_ERROR");
    $finish;
  end

  initial begin : stimulus
    int          pick;
    logic [14:0] bnd;
    logic [31:0] sv;
    rst = 1'b1;

    // directed: bound extremes, zero bound, loads with ignored bound,
    // zero seed with the lockup escape, and draws that ignore seed_value
    add_request(ACT_DRAW, 15'd1, $urandom());
    add_request(ACT_DRAW, 15'd32767, $urandom());
    add_request(ACT_DRAW, 15'd0, $urandom());
    add_request(ACT_DRAW, 15'd2, 32'hFFFF_FFFF);
    add_request(ACT_DRAW, 15'd512, 32'h0);
    add_request(ACT_DRAW, 15'd511, $urandom());
    add_request(ACT_DRAW, 15'd1023, $urandom());
    add_request(ACT_LOAD, 15'd32767, 32'h0);
    add_request(ACT_DRAW, 15'd0, $urandom());      // error keeps the zero seed
    add_request(ACT_DRAW, 15'd100, $urandom());    // escapes the zero seed
    add_request(ACT_LOAD, 15'd0, 32'hFFFF_FFFF);
    add_request(ACT_DRAW, 15'd32767, $urandom());
    add_request(ACT_LOAD, 15'd5, 32'h0000_0001);
    add_request(ACT_DRAW, 15'd7, $urandom());
    add_request(ACT_LOAD, 15'h7FFF, 32'h8000_0000);
    add_request(ACT_DRAW, 15'd3, $urandom());
    add_request(ACT_LOAD, 15'h2AAA, 32'h0);
    add_request(ACT_DRAW, 15'd1, $urandom());      // escape with unit bound
    add_request(ACT_LOAD, 15'h5555, 32'hAAAA_AAAA);
    add_request(ACT_DRAW, 15'h4000, $urandom());
    add_request(ACT_DRAW, 15'h5555, $urandom());
    add_request(ACT_DRAW, 15'h2AAA, $urandom());
    add_request(ACT_LOAD, 15'd0, SEED_RESET);
    add_request(ACT_DRAW, 15'd13, $urandom());
    if (pending_requests.size() > DIRECTED_MAX)
      $display("directed list longer than planned");

    // random: mostly draws over a spread of bounds, some loads and zero bounds
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      pick = $urandom_range(99);
      sv   = $urandom();
      if (pick < 12) begin
        if ($urandom_range(7) == 0) sv = '0;
        add_request(ACT_LOAD, 15'($urandom()), sv);
      end else if (pick < 17) begin
        add_request(ACT_DRAW, 15'd0, sv);
      end else begin
        pick = $urandom_range(99);
        if (pick < 40)      bnd = 15'($urandom_range(16, 1));
        else if (pick < 70) bnd = 15'($urandom_range(32767, 1));
        else if (pick < 85) bnd = 15'($urandom_range(530, 500));
        else                bnd = 15'(1 << $urandom_range(14));
        add_request(ACT_DRAW, bnd, sv);
      end
    end
    total_items = pending_requests.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (pending_requests.size() != 0 || req_ch.valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d draws, %0d seed loads, %0d zero-bound requests, %0d lockup escapes",
             n_draws, n_loads, n_zero_bound, n_escapes);
    $display("%0d responses checked, %0d mismatches", results_seen, fail_count);
    if (fail_count == 0 && expected_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: lfsr_bounded_random_draw_unit.f
hdl/lbrd_pkg.sv
hdl/lbrd_stream_if.sv
hdl/lbrd_lfsr.sv
hdl/lbrd_rem.sv
hdl/lfsr_bounded_random_draw_unit.sv
tb/tb_top.sv
